>>> src/dfrm_pkg.sv
// ----------------------------------------------------------------------------
// dfrm_pkg
// Shared types and codes for the preamble/checksum deframer.
// ----------------------------------------------------------------------------
package dfrm_pkg;

   // parse phases
   localparam logic [2:0] PH_MARKS   = 3'd0;
   localparam logic [2:0] PH_HEADER  = 3'd1;
   localparam logic [2:0] PH_PAYLOAD = 3'd2;
   localparam logic [2:0] PH_CHECK   = 3'd3;
   localparam logic [2:0] PH_TRAIL   = 3'd4;
   localparam logic [2:0] PH_DONE    = 3'd5;
   localparam logic [2:0] PH_IDLE    = 3'd6;

   // verdict codes
   localparam logic [2:0] VERDICT_OK    = 3'd0;
   localparam logic [2:0] VERDICT_LEAD  = 3'd1;
   localparam logic [2:0] VERDICT_SYNC  = 3'd2;
   localparam logic [2:0] VERDICT_CSUM  = 3'd3;
   localparam logic [2:0] VERDICT_T55   = 3'd4;
   localparam logic [2:0] VERDICT_TED   = 3'd5;
   localparam logic [2:0] VERDICT_TYPE  = 3'd6;
   localparam logic [2:0] VERDICT_SHORT = 3'd7;

   // marker bytes
   localparam logic [7:0] LEAD_BYTE  = 8'hBE;
   localparam logic [7:0] SYNC_BYTE  = 8'hAA;
   localparam logic [7:0] T55_BYTE   = 8'h55;
   localparam logic [7:0] TED_BYTE   = 8'hED;
   localparam logic [7:0] TYPE_RESET = 8'h01;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       first_of_datagram;
      logic       last_of_datagram;
   } item_type;

   typedef struct packed {
      logic [7:0] payload_byte;
      logic       payload_valid;
      logic       verdict_valid;
      logic [2:0] verdict;
   } result_type;

endpackage

>>> src/dfrm_parser.sv
// ----------------------------------------------------------------------------
// dfrm_parser
// Frame state and the per-byte step: checks markers, header, payload sum.
// ----------------------------------------------------------------------------
module dfrm_parser #(
   parameter int MARK_COUNT = 8
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 step_en,
   input  dfrm_pkg::item_type   item,
   input  logic [7:0]           accepted_type,
   output dfrm_pkg::result_type result
);

   localparam logic [15:0] MarkEnd  = 16'(MARK_COUNT);
   localparam logic [15:0] TrailEnd = 16'(2 * MARK_COUNT);

   logic [2:0]  phase_ff, phase_in;
   logic [15:0] position_ff, position_in;
   logic [15:0] length_ff, length_in;
   logic [7:0]  sum_ff, sum_in;
   logic [7:0]  type_ff, type_in;
   logic [2:0]  error_ff, error_in;

   always_comb begin
      logic [2:0]  ph;
      logic [15:0] pos;
      logic [15:0] pos_inc;
      logic [7:0]  b;
      logic        active;
      logic [2:0]  err_code;
      logic        err_hit;

      b        = item.data_byte;
      err_code = dfrm_pkg::VERDICT_OK;
      err_hit  = 1'b0;

      // a first byte restarts the parse before the byte is taken
      if (item.first_of_datagram) begin
         ph          = dfrm_pkg::PH_MARKS;
         pos         = '0;
         length_in   = '0;
         sum_in      = '0;
         type_in     = '0;
         error_in    = dfrm_pkg::VERDICT_OK;
      end else begin
         ph          = phase_ff;
         pos         = position_ff;
         length_in   = length_ff;
         sum_in      = sum_ff;
         type_in     = type_ff;
         error_in    = error_ff;
      end
      active      = (ph != dfrm_pkg::PH_IDLE);
      pos_inc     = pos + 16'd1;
      phase_in    = ph;
      position_in = pos;
      result      = '0;

      unique case (ph)
         dfrm_pkg::PH_MARKS: begin
            if (pos < MarkEnd) begin
               err_hit  = (b != dfrm_pkg::LEAD_BYTE);
               err_code = dfrm_pkg::VERDICT_LEAD;
            end else begin
               err_hit  = (b != dfrm_pkg::SYNC_BYTE);
               err_code = dfrm_pkg::VERDICT_SYNC;
            end
            position_in = pos_inc;
            if (pos_inc >= TrailEnd) begin
               phase_in    = dfrm_pkg::PH_HEADER;
               position_in = '0;
            end
         end
         dfrm_pkg::PH_HEADER: begin
            if (pos == 16'd0) begin
               length_in   = {8'd0, b};
               position_in = 16'd1;
            end else if (pos == 16'd1) begin
               length_in   = {b, length_in[7:0]};
               position_in = 16'd2;
            end else begin
               type_in     = b;
               position_in = '0;
               phase_in    = (length_in == 16'd0) ? dfrm_pkg::PH_CHECK
                                                  : dfrm_pkg::PH_PAYLOAD;
            end
         end
         dfrm_pkg::PH_PAYLOAD: begin
            result.payload_byte  = b;
            result.payload_valid = 1'b1;
            sum_in               = sum_in + b;
            position_in          = pos_inc;
            if (pos_inc >= length_in) begin
               position_in = '0;
               phase_in    = dfrm_pkg::PH_CHECK;
            end
         end
         dfrm_pkg::PH_CHECK: begin
            err_hit     = (b != sum_in);
            err_code    = dfrm_pkg::VERDICT_CSUM;
            position_in = '0;
            phase_in    = dfrm_pkg::PH_TRAIL;
         end
         dfrm_pkg::PH_TRAIL: begin
            if (pos < MarkEnd) begin
               err_hit  = (b != dfrm_pkg::T55_BYTE);
               err_code = dfrm_pkg::VERDICT_T55;
            end else begin
               err_hit  = (b != dfrm_pkg::TED_BYTE);
               err_code = dfrm_pkg::VERDICT_TED;
            end
            position_in = pos_inc;
            if (pos_inc >= TrailEnd) begin
               position_in = '0;
               phase_in    = dfrm_pkg::PH_DONE;
            end
         end
         default: begin
         end
      endcase

      // first error wins
      if (err_hit && (error_in == dfrm_pkg::VERDICT_OK)) begin
         error_in = err_code;
      end

      if (item.last_of_datagram && active) begin
         result.verdict_valid = 1'b1;
         priority if (error_in != dfrm_pkg::VERDICT_OK) begin
            result.verdict = error_in;
         end else if (phase_in != dfrm_pkg::PH_DONE) begin
            result.verdict = dfrm_pkg::VERDICT_SHORT;
         end else if (type_in != accepted_type) begin
            result.verdict = dfrm_pkg::VERDICT_TYPE;
         end else begin
            result.verdict = dfrm_pkg::VERDICT_OK;
         end
         phase_in    = dfrm_pkg::PH_IDLE;
         position_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= dfrm_pkg::PH_MARKS;
         position_ff <= '0;
         length_ff   <= '0;
         sum_ff      <= '0;
         type_ff     <= '0;
         error_ff    <= dfrm_pkg::VERDICT_OK;
      end else if (step_en) begin
         phase_ff    <= phase_in;
         position_ff <= position_in;
         length_ff   <= length_in;
         sum_ff      <= sum_in;
         type_ff     <= type_in;
         error_ff    <= error_in;
      end
   end

endmodule

>>> src/preamble_frame_checksum_deframer.sv
// ----------------------------------------------------------------------------
// preamble_frame_checksum_deframer
// Byte-wise checker for lead/sync framed datagrams with additive checksum.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one datagram byte per request with first/last markers.
//   Every request yields exactly one response on rsp_*: the payload byte
//   (when the byte was payload) and, on a datagram's last byte, a verdict.
//   csr_* writes accepted_type; csr_ready is always high, and writes are
//   expected only while no request is in flight.
// Path: an accepted request passes two register stages, the request
//   register and then the response register, before it shows on rsp_*.
// Throughput: one request per cycle unless rsp_stall holds a response, set
//   by the parse step between the request and response registers.
// Stall: when rsp_stall holds a pending response, the request register
//   still drains into it once it empties; req_stall rises only when both
//   stages are full and the response is stalled.
// Reset: both stages empty, parse state back to the lead marks,
//   accepted_type back to 0x01.
// ----------------------------------------------------------------------------
module preamble_frame_checksum_deframer #(
   parameter int MARK_COUNT = 8
) (
   input  logic       clock,
   input  logic       reset,
   // request channel
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_data_byte,
   input  logic       req_first_of_datagram,
   input  logic       req_last_of_datagram,
   // response channel
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_payload_byte,
   output logic       rsp_payload_valid,
   output logic       rsp_verdict_valid,
   output logic [2:0] rsp_verdict,
   // configuration write
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic [7:0] csr_data
);

   logic                 req_valid_ff;
   dfrm_pkg::item_type   req_item_ff;
   logic                 rsp_valid_ff;
   dfrm_pkg::result_type rsp_item_ff;
   dfrm_pkg::result_type step_result;
   logic [7:0]           accepted_type_ff;
   logic                 out_free;
   logic                 step_en;

   // response register can take a new value this cycle
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign step_en   = req_valid_ff && out_free;
   assign req_stall = req_valid_ff && !out_free;
   assign csr_ready = 1'b1;

   // request register
   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
      end else if (!req_stall) begin
         req_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         req_item_ff <= '{data_byte:         req_data_byte,
                          first_of_datagram: req_first_of_datagram,
                          last_of_datagram:  req_last_of_datagram};
      end
   end

   // configuration register
   always_ff @(posedge clock) begin
      if (reset) begin
         accepted_type_ff <= dfrm_pkg::TYPE_RESET;
      end else if (csr_valid && csr_ready) begin
         accepted_type_ff <= csr_data;
      end
   end

   dfrm_parser #(
      .MARK_COUNT (MARK_COUNT)
   ) u_parser (
      .clock         (clock),
      .reset         (reset),
      .step_en       (step_en),
      .item          (req_item_ff),
      .accepted_type (accepted_type_ff),
      .result        (step_result)
   );

   // response register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_free) begin
         rsp_valid_ff <= req_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (step_en) begin
         rsp_item_ff <= step_result;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_payload_byte  = rsp_item_ff.payload_byte;
   assign rsp_payload_valid = rsp_item_ff.payload_valid;
   assign rsp_verdict_valid = rsp_item_ff.verdict_valid;
   assign rsp_verdict       = rsp_item_ff.verdict;

endmodule

>>> src/dfrm_checker.sv
// ----------------------------------------------------------------------------
// dfrm_checker
// Port-level checks for the deframer, bound to the top level.
// ----------------------------------------------------------------------------
module dfrm_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_stall,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic [7:0] rsp_payload_byte,
   input logic       rsp_payload_valid,
   input logic       rsp_verdict_valid,
   input logic [2:0] rsp_verdict
);

   // back-pressure only reaches the request side through a stalled response
   assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (rsp_valid && rsp_stall))
      else $error("req_stall without a stalled response");

   // a request taken while no response is valid reaches rsp_valid through the request and response registers
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall && !rsp_valid) |=> ##1 rsp_valid)
      else $error("request lost in pipeline");

   // unused fields read as zero
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_payload_valid || (rsp_payload_byte == 8'd0)) &&
                     (rsp_verdict_valid || (rsp_verdict == dfrm_pkg::VERDICT_OK))))
      else $error("inactive response field not zero");

   // stalled response holds
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_payload_byte) &&
                                    $stable(rsp_verdict) && $stable(rsp_verdict_valid)))
      else $error("stalled response changed");

endmodule

bind preamble_frame_checksum_deframer dfrm_checker u_dfrm_checker (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req_valid),
   .req_stall         (req_stall),
   .rsp_valid         (rsp_valid),
   .rsp_stall         (rsp_stall),
   .rsp_payload_byte  (rsp_payload_byte),
   .rsp_payload_valid (rsp_payload_valid),
   .rsp_verdict_valid (rsp_verdict_valid),
   .rsp_verdict       (rsp_verdict)
);
